// ===== sv/dnp3_link_frame_deframer_core_defines.svh =====
// assertion helpers shared by the deframer
`ifndef DNP3_LINK_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define DNP3_LINK_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, idle during reset
`define DLFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define DLFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dlfd_pkg.sv =====
package dlfd_pkg;

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_FRAME = 2'd2;

  localparam logic [7:0] SYNC_FIRST    = 8'h05;
  localparam logic [7:0] SYNC_SECOND   = 8'h64;
  localparam logic [7:0] MIN_LEN_BYTE  = 8'd5;
  localparam logic [7:0] MIN_FUNC_USER = 8'd3;
  localparam logic [8:0] HEADER_BYTES  = 9'd10;
  localparam logic [8:0] CRC_ROUND     = 9'd15;

  localparam logic [8:0] POS_AFTER_LEN = 9'd3;
  localparam logic [8:0] POS_DEST_LO   = 9'd4;
  localparam logic [8:0] POS_DEST_HI   = 9'd5;
  localparam logic [8:0] POS_SRC_LO    = 9'd6;
  localparam logic [8:0] POS_SRC_HI    = 9'd7;
  localparam logic [8:0] POS_FUNC      = 9'd12;

  localparam int M_TDATA_W = 56;

  typedef struct packed {
    logic       valid;
    logic       dir;
    logic [7:0] data;
  } dlfd_in_t;

  typedef struct packed {
    logic        saw_sync;
    logic [1:0]  phase;
    logic [8:0]  pos;
    logic [8:0]  total;
    logic [7:0]  user_len;
    logic [15:0] dest;
    logic [15:0] src;
    logic [7:0]  func;
  } dlfd_state_t;

  typedef struct packed {
    logic        dir;
    logic [15:0] dest;
    logic [15:0] src;
    logic [7:0]  func;
    logic        present;
    logic [8:0]  length;
  } dlfd_result_t;

endpackage

// ===== sv/dnp3_link_frame_deframer_core.sv =====
// the last byte passes the input register, then its result the output register
// throughput: one byte per cycle unless a result waits on m_tready, from either direction in any interleaving
// each direction keeps its own hunt/length/frame state in a register bank
// a result waiting on m_tready holds back the next byte, whether it closes a frame or not
// reset clears every direction to hunting and empties both stage registers
module dnp3_link_frame_deframer_core #(
  parameter int NUM_DIRECTIONS = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // data_byte
  input  logic                           s_tuser,  // direction
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // dest_addr[15:0], src_addr[31:16], func_code[39:32], func_present[40],
  // frame_length[49:41], zero fill
  output logic [dlfd_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser   // frame_direction
);
  import dlfd_pkg::*;
  `include "dnp3_link_frame_deframer_core_defines.svh"

  dlfd_in_t     in_q;
  dlfd_result_t result;
  logic         advance;
  logic         load;
  logic         free;

  assign advance = in_q.valid && free;

  dlfd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_q     (in_q)
  );

  dlfd_parser #(
    .NUM_DIRECTIONS (NUM_DIRECTIONS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .in_q    (in_q),
    .advance (advance),
    .load    (load),
    .result  (result)
  );

  dlfd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .result   (result),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `DLFD_ASSERT_NOW(a_len_range, m_tvalid,
                   m_tdata[49:41] >= 9'd10 && m_tdata[49:41] <= 9'd292,
                   "frame length out of range")
  `DLFD_ASSERT_NOW(a_func_absent, m_tvalid && !m_tdata[40], m_tdata[39:32] == 8'h00,
                   "function code without user data")
  `DLFD_ASSERT_NEXT(a_in_hold, in_q.valid && !advance, in_q.valid, "stalled byte lost")
  `DLFD_ASSERT_NOW(a_load_free, load, free, "result loaded over a waiting one")

endmodule

// ===== sv/dlfd_in_stage.sv =====
module dlfd_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tuser,
  input  logic             advance,
  output dlfd_pkg::dlfd_in_t in_q
);
  import dlfd_pkg::*;

  assign s_tready = !in_q.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q.valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_q.valid <= 1'b1;
    end else if (advance) begin
      in_q.valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_q.dir  <= s_tuser;
      in_q.data <= s_tdata;
    end
  end

endmodule

// ===== sv/dlfd_parser.sv =====
module dlfd_parser #(
  parameter int NUM_DIRECTIONS = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dlfd_pkg::dlfd_in_t     in_q,
  input  logic                   advance,
  output logic                   load,
  output dlfd_pkg::dlfd_result_t result
);
  import dlfd_pkg::*;

  localparam logic [1:0] NUM_DIR_L = 2'(NUM_DIRECTIONS);

  dlfd_state_t st [NUM_DIRECTIONS];
  dlfd_state_t cur;
  dlfd_state_t st_next;
  logic        dir_ok;
  logic        emit;
  logic [7:0]  b;
  logic [7:0]  u;
  logic [8:0]  round_sum;
  logic [4:0]  blocks;
  logic        present;

  assign b      = in_q.data;
  assign dir_ok = {1'b0, in_q.dir} < NUM_DIR_L;

  always_comb begin
    cur = st[0];
    for (int d = 0; d < NUM_DIRECTIONS; d++) begin
      if (in_q.dir == 1'(d)) cur = st[d];
    end
  end

  assign u         = b - MIN_LEN_BYTE;
  assign round_sum = {1'b0, u} + CRC_ROUND;
  assign blocks    = round_sum[8:4];
  assign present   = cur.user_len >= MIN_FUNC_USER;

  always_comb begin
    st_next = cur;
    emit    = 1'b0;
    unique case (cur.phase)
      PH_LEN: begin
        if (b < MIN_LEN_BYTE) begin
          st_next.phase    = PH_HUNT;
          st_next.saw_sync = (b == SYNC_FIRST);
        end else begin
          st_next.user_len = u;
          st_next.total    = HEADER_BYTES + {1'b0, u} + {3'b000, blocks, 1'b0};
          st_next.pos      = POS_AFTER_LEN;
          st_next.dest     = '0;
          st_next.src      = '0;
          st_next.func     = '0;
          st_next.phase    = PH_FRAME;
        end
      end
      PH_FRAME: begin
        if (cur.pos == POS_DEST_LO) st_next.dest[7:0]  = b;
        if (cur.pos == POS_DEST_HI) st_next.dest[15:8] = b;
        if (cur.pos == POS_SRC_LO)  st_next.src[7:0]   = b;
        if (cur.pos == POS_SRC_HI)  st_next.src[15:8]  = b;
        if (cur.pos == POS_FUNC && present) st_next.func = b;
        // last byte of the frame closes it
        if (({1'b0, cur.pos} + 10'd1) >= {1'b0, cur.total}) begin
          emit             = 1'b1;
          st_next.phase    = PH_HUNT;
          st_next.saw_sync = 1'b0;
          st_next.pos      = '0;
        end else begin
          st_next.pos = cur.pos + 9'd1;
        end
      end
      default: begin
        // hunting, also taken for the unused phase code
        if (cur.saw_sync && b == SYNC_SECOND) begin
          st_next.saw_sync = 1'b0;
          st_next.phase    = PH_LEN;
        end else begin
          st_next.saw_sync = (b == SYNC_FIRST);
        end
      end
    endcase
  end

  assign load           = advance && dir_ok && emit;
  assign result.dir     = in_q.dir;
  assign result.dest    = st_next.dest;
  assign result.src     = st_next.src;
  assign result.func    = present ? st_next.func : 8'h00;
  assign result.present = present;
  assign result.length  = cur.total;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NUM_DIRECTIONS; d++) begin
        st[d] <= '0;
      end
    end else if (advance && dir_ok) begin
      for (int d = 0; d < NUM_DIRECTIONS; d++) begin
        if (in_q.dir == 1'(d)) st[d] <= st_next;
      end
    end
  end

endmodule

// ===== sv/dlfd_out_stage.sv =====
module dlfd_out_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  dlfd_pkg::dlfd_result_t         result,
  output logic                           free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dlfd_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser
);
  import dlfd_pkg::*;

  dlfd_result_t res_q;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= result;
  end

  assign m_tdata = {6'b000000, res_q.length, res_q.present, res_q.func,
                    res_q.src, res_q.dest};
  assign m_tuser = res_q.dir;

endmodule
